@@ rtl/core/wmr_pkg.sv @@
// wmr_pkg: shared sizes, opcode and character codes, payload and control types
// for the word mangling rule block. No dependencies.
package wmr_pkg;

  localparam int MAX_WORD   = 64;
  localparam int MAX_RULE   = 32;
  localparam int AW         = $clog2(MAX_WORD);
  localparam int LW         = $clog2(MAX_WORD + 1);
  localparam int CW         = (LW + 1 > 7) ? LW + 1 : 7;
  localparam int RIW        = 6;
  localparam int CFG_IW     = 3;
  localparam int NRULE_REGS = 4;

  localparam logic [CFG_IW-1:0] CFG_RULE_LEN = 3'd4;

  localparam logic [7:0] OP_NOP     = 8'h3A;
  localparam logic [7:0] OP_LOWER   = 8'h6C;
  localparam logic [7:0] OP_UPPER   = 8'h75;
  localparam logic [7:0] OP_CAP     = 8'h63;
  localparam logic [7:0] OP_ICAP    = 8'h43;
  localparam logic [7:0] OP_TOGGLE  = 8'h74;
  localparam logic [7:0] OP_REV     = 8'h72;
  localparam logic [7:0] OP_DUP     = 8'h64;
  localparam logic [7:0] OP_REFL    = 8'h66;
  localparam logic [7:0] OP_ROTL    = 8'h7B;
  localparam logic [7:0] OP_ROTR    = 8'h7D;
  localparam logic [7:0] OP_DROPF   = 8'h5B;
  localparam logic [7:0] OP_DROPL   = 8'h5D;
  localparam logic [7:0] OP_DEL     = 8'h44;
  localparam logic [7:0] OP_APPEND  = 8'h24;
  localparam logic [7:0] OP_PREPEND = 8'h5E;
  localparam logic [7:0] OP_PURGE   = 8'h40;
  localparam logic [7:0] OP_SUBST   = 8'h73;
  localparam logic [7:0] OP_OVER    = 8'h6F;
  localparam logic [7:0] OP_INS     = 8'h69;
  localparam logic [7:0] OP_LESS    = 8'h3C;
  localparam logic [7:0] OP_MORE    = 8'h3E;
  localparam logic [7:0] OP_EQ      = 8'h5F;

  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CASE_DIFF = 8'h20;
  localparam logic [7:0] ALPHA_POS = 8'd10;

  typedef struct packed {
    logic [7:0] word_char;
    logic       no_char;
    logic       last_char;
  } word_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       rejected;
    logic       truncated;
    logic       last_out;
  } result_item_t;

  typedef enum logic [2:0] {
    ST_LOAD, ST_FETCH, ST_COPY, ST_EMIT_RD, ST_EMIT_WR
  } state_t;

  typedef enum logic [3:0] {
    CM_LOWER, CM_UPPER, CM_CAP, CM_ICAP, CM_TOGGLE, CM_REV, CM_DUP, CM_REFL,
    CM_ROTL, CM_ROTR, CM_DROPF, CM_DEL, CM_INS, CM_PURGE, CM_SUBST
  } copy_mode_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic copy_run;
    logic emit_rd;
    logic emit_wr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rule_done;
    logic exec_reject;
    logic exec_copy;
    logic copy_done;
    logic out_free;
    logic emit_last;
  } dp_stat_t;

  function automatic logic [7:0] lower_of(input logic [7:0] c);
    return (c >= CH_UA && c <= CH_UZ) ? c + CASE_DIFF : c;
  endfunction

  function automatic logic [7:0] upper_of(input logic [7:0] c);
    return (c >= CH_LA && c <= CH_LZ) ? c - CASE_DIFF : c;
  endfunction

  function automatic logic pos_ok(input logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ);
  endfunction

  function automatic logic [5:0] pos_val(input logic [7:0] c);
    logic [7:0] t;
    t = (c <= CH_9) ? c - CH_0 : c - CH_UA + ALPHA_POS;
    return t[5:0];
  endfunction

endpackage

@@ rtl/core/wmr_ctrl.sv @@
// wmr_ctrl: sequencer for load, opcode fetch, buffer copy passes and emission.
// Depends on wmr_pkg; drives the datapath by command struct.
module wmr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              word_valid,
  input  logic              word_last,
  output logic              word_ready,
  input  wmr_pkg::dp_stat_t stat,
  output wmr_pkg::ctrl_cmd_t cmd
);
  import wmr_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (word_valid && word_last) state_next = ST_FETCH;
      end
      ST_FETCH: begin
        if (stat.rule_done || stat.exec_reject) state_next = ST_EMIT_RD;
        else if (stat.exec_copy) state_next = ST_COPY;
      end
      ST_COPY: begin
        if (stat.copy_done) state_next = ST_FETCH;
      end
      ST_EMIT_RD: state_next = ST_EMIT_WR;
      ST_EMIT_WR: begin
        if (stat.out_free) state_next = stat.emit_last ? ST_LOAD : ST_EMIT_RD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd        = '0;
    word_ready = 1'b0;
    case (state)
      ST_LOAD: begin
        word_ready = 1'b1;
        cmd.load   = word_valid;
      end
      ST_FETCH:   cmd.exec = !stat.rule_done;
      ST_COPY:    cmd.copy_run = 1'b1;
      ST_EMIT_RD: cmd.emit_rd = 1'b1;
      ST_EMIT_WR: cmd.emit_wr = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/core/wmr_dp.sv @@
// wmr_dp: rule registers, two-bank word buffer, opcode decode and copy engine.
// Depends on wmr_pkg; commanded by wmr_ctrl.
module wmr_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic [wmr_pkg::CFG_IW-1:0] cfg_index,
  input  logic [63:0]                cfg_data,
  input  wmr_pkg::word_item_t        word,
  input  wmr_pkg::ctrl_cmd_t         cmd,
  output wmr_pkg::dp_stat_t          stat,
  output logic                       result_valid,
  input  logic                       result_ready,
  output wmr_pkg::result_item_t      result
);
  import wmr_pkg::*;

  localparam int MEM_DEPTH = 2 ** (AW + 1);
  localparam logic [LW-1:0] MAXL = LW'(MAX_WORD);
  localparam logic [CW-1:0] MAXC = CW'(MAX_WORD);

  logic [7:0]  mem [MEM_DEPTH];
  logic [7:0]  rdata;
  logic        bank;
  logic [LW-1:0] wlen, cnt, nlen, k, w, pk, e;
  logic        trunc, rej, pv;
  logic [RIW-1:0] ri;
  copy_mode_t  mode;
  logic [CW-1:0] par_p;
  logic [7:0]  par_a, par_b;
  logic [63:0] rule_regs [NRULE_REGS];
  logic [5:0]  rule_len;
  logic [64*NRULE_REGS-1:0] rule_flat;

  always_comb begin
    for (int i = 0; i < NRULE_REGS; i++) rule_flat[i*64 +: 64] = rule_regs[i];
  end

  // opcode fetch
  logic [4:0] bi0, bi1, bi2;
  logic [7:0] op, arg_a, arg_b;
  logic [RIW-1:0] rl;
  logic [1:0] need;
  logic [RIW:0] ri_adv;
  logic missing, pok;
  logic [CW-1:0] pc, wlc, dbl;

  assign bi0   = ri[4:0];
  assign bi1   = ri[4:0] + 5'd1;
  assign bi2   = ri[4:0] + 5'd2;
  assign op    = rule_flat[{bi0, 3'b000} +: 8];
  assign arg_a = rule_flat[{bi1, 3'b000} +: 8];
  assign arg_b = rule_flat[{bi2, 3'b000} +: 8];
  assign rl    = (rule_len > RIW'(MAX_RULE)) ? RIW'(MAX_RULE) : rule_len;
  assign pok   = pos_ok(arg_a);
  assign pc    = CW'(pos_val(arg_a));
  assign wlc   = CW'(wlen);
  assign dbl   = wlc << 1;

  always_comb begin
    case (op)
      OP_DEL, OP_LESS, OP_MORE, OP_EQ, OP_APPEND, OP_PREPEND, OP_PURGE: need = 2'd1;
      OP_SUBST, OP_OVER, OP_INS: need = 2'd2;
      default: need = 2'd0;
    endcase
  end

  assign ri_adv  = {1'b0, ri} + (RIW+1)'(1) + (RIW+1)'(need);
  assign missing = ri_adv > {1'b0, rl};

  // decode of one opcode
  logic x_rej, x_copy, x_trunc, x_wr, x_len_wr;
  copy_mode_t x_mode;
  logic [LW-1:0] x_cnt, x_nlen, x_len;
  logic [CW-1:0] x_p;
  logic [7:0] x_b, x_wdata;
  logic [AW-1:0] x_waddr;

  always_comb begin
    x_rej = 1'b0; x_copy = 1'b0; x_trunc = 1'b0; x_wr = 1'b0; x_len_wr = 1'b0;
    x_mode = CM_LOWER; x_cnt = wlen; x_nlen = wlen; x_len = wlen;
    x_p = '0; x_b = arg_b; x_wdata = arg_a; x_waddr = wlen[AW-1:0];
    if (missing) begin
      x_rej = 1'b1;
    end else begin
      case (op)
        OP_NOP: x_rej = 1'b0;
        OP_LOWER:  begin x_copy = 1'b1; x_mode = CM_LOWER;  end
        OP_UPPER:  begin x_copy = 1'b1; x_mode = CM_UPPER;  end
        OP_CAP:    begin x_copy = 1'b1; x_mode = CM_CAP;    end
        OP_ICAP:   begin x_copy = 1'b1; x_mode = CM_ICAP;   end
        OP_TOGGLE: begin x_copy = 1'b1; x_mode = CM_TOGGLE; end
        OP_REV:    begin x_copy = 1'b1; x_mode = CM_REV;    end
        OP_ROTL:   begin x_copy = 1'b1; x_mode = CM_ROTL;   end
        OP_ROTR:   begin x_copy = 1'b1; x_mode = CM_ROTR;   end
        OP_PURGE:  begin x_copy = 1'b1; x_mode = CM_PURGE;  end
        OP_SUBST:  begin x_copy = 1'b1; x_mode = CM_SUBST;  end
        OP_DUP, OP_REFL: begin
          x_copy = 1'b1;
          x_mode = (op == OP_DUP) ? CM_DUP : CM_REFL;
          if (dbl > MAXC) begin
            x_trunc = 1'b1;
            x_nlen  = MAXL;
          end else begin
            x_nlen = dbl[LW-1:0];
          end
          x_cnt = x_nlen;
        end
        OP_DROPF: begin
          if (wlen != '0) begin
            x_copy = 1'b1; x_mode = CM_DROPF;
            x_cnt = wlen - LW'(1); x_nlen = wlen - LW'(1);
          end
        end
        OP_DROPL: begin
          if (wlen != '0) begin
            x_len_wr = 1'b1; x_len = wlen - LW'(1);
          end
        end
        OP_DEL: begin
          if (pok && pc < wlc) begin
            x_copy = 1'b1; x_mode = CM_DEL; x_p = pc;
            x_cnt = wlen - LW'(1); x_nlen = wlen - LW'(1);
          end
        end
        OP_APPEND: begin
          if (wlen < MAXL) begin
            x_wr = 1'b1; x_len_wr = 1'b1; x_len = wlen + LW'(1);
          end else begin
            x_trunc = 1'b1;
          end
        end
        OP_PREPEND, OP_INS: begin
          if (op == OP_PREPEND || (pok && pc <= wlc)) begin
            x_copy = 1'b1; x_mode = CM_INS;
            x_p = (op == OP_PREPEND) ? '0 : pc;
            x_b = (op == OP_PREPEND) ? arg_a : arg_b;
            if (wlen == MAXL) begin
              x_trunc = 1'b1; x_nlen = MAXL;
            end else begin
              x_nlen = wlen + LW'(1);
            end
            x_cnt = x_nlen;
          end
        end
        OP_OVER: begin
          if (pok && pc < wlc) begin
            x_wr = 1'b1; x_waddr = pc[AW-1:0]; x_wdata = arg_b;
          end
        end
        OP_LESS: x_rej = !pok || wlc >= pc;
        OP_MORE: x_rej = pok && wlc <= pc;
        OP_EQ:   x_rej = !pok || wlc != pc;
        default: x_rej = 1'b1;
      endcase
    end
  end

  // copy engine: source index for each destination byte
  logic [CW-1:0] kc, src;
  logic [7:0] cval;
  logic copy_done, issue, keep;

  assign kc = CW'(k);

  always_comb begin
    case (mode)
      CM_REV:   src = wlc - CW'(1) - kc;
      CM_DUP:   src = (kc < wlc) ? kc : kc - wlc;
      CM_REFL:  src = (kc < wlc) ? kc : dbl - CW'(1) - kc;
      CM_ROTL:  src = (kc + CW'(1) == wlc) ? '0 : kc + CW'(1);
      CM_ROTR:  src = (kc == '0) ? wlc - CW'(1) : kc - CW'(1);
      CM_DROPF: src = kc + CW'(1);
      CM_DEL:   src = (kc < par_p) ? kc : kc + CW'(1);
      CM_INS:   src = (kc < par_p) ? kc : kc - CW'(1);
      default:  src = kc;
    endcase
  end

  always_comb begin
    case (mode)
      CM_LOWER:  cval = lower_of(rdata);
      CM_UPPER:  cval = upper_of(rdata);
      CM_CAP:    cval = (pk == '0) ? upper_of(rdata) : lower_of(rdata);
      CM_ICAP:   cval = (pk == '0) ? lower_of(rdata) : upper_of(rdata);
      CM_TOGGLE: cval = (rdata >= CH_LA && rdata <= CH_LZ) ? upper_of(rdata)
                                                          : lower_of(rdata);
      CM_SUBST:  cval = (rdata == par_a) ? par_b : rdata;
      CM_INS:    cval = (CW'(pk) == par_p) ? par_b : rdata;
      default:   cval = rdata;
    endcase
  end

  assign copy_done = (k >= cnt) && !pv;
  assign issue     = cmd.copy_run && (k < cnt);
  assign keep      = (mode != CM_PURGE) || (rdata != par_a);

  // emission status
  logic emit_last, out_free;
  assign emit_last = rej || (wlen == '0) || ({1'b0, e} + (LW+1)'(1) == {1'b0, wlen});
  assign out_free  = !result_valid || result_ready;

  assign stat.rule_done   = ri >= rl;
  assign stat.exec_reject = x_rej;
  assign stat.exec_copy   = x_copy;
  assign stat.copy_done   = copy_done;
  assign stat.out_free    = out_free;
  assign stat.emit_last   = emit_last;

  // buffer port selection
  logic we, re;
  logic [AW:0] wa, ra;
  logic [7:0] wd;

  always_comb begin
    we = 1'b0; wa = {bank, wlen[AW-1:0]}; wd = word.word_char;
    re = 1'b0; ra = {bank, e[AW-1:0]};
    if (cmd.load) begin
      we = !word.no_char && (wlen < MAXL);
    end else if (cmd.exec) begin
      we = x_wr && !x_rej;
      wa = {bank, x_waddr};
      wd = x_wdata;
    end else if (cmd.copy_run) begin
      we = pv && keep;
      wa = {~bank, (mode == CM_PURGE) ? w[AW-1:0] : pk[AW-1:0]};
      wd = cval;
      re = issue;
      ra = {bank, src[AW-1:0]};
    end else if (cmd.emit_rd) begin
      re = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rdata <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NRULE_REGS; i++) rule_regs[i] <= '0;
      rule_len     <= '0;
      bank         <= 1'b0;
      wlen         <= '0;
      trunc        <= 1'b0;
      rej          <= 1'b0;
      ri           <= '0;
      k            <= '0;
      w            <= '0;
      e            <= '0;
      pv           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index < CFG_IW'(NRULE_REGS)) rule_regs[cfg_index[1:0]] <= cfg_data;
        else if (cfg_index == CFG_RULE_LEN) rule_len <= cfg_data[5:0];
      end

      if (cmd.load) begin
        if (!word.no_char) begin
          if (wlen < MAXL) wlen <= wlen + LW'(1);
          else trunc <= 1'b1;
        end
        if (word.last_char) begin
          ri  <= '0;
          rej <= 1'b0;
          e   <= '0;
        end
      end

      if (cmd.exec) begin
        ri <= ri_adv[RIW-1:0];
        if (x_rej) rej <= 1'b1;
        if (x_trunc) trunc <= 1'b1;
        if (x_len_wr) wlen <= x_len;
        if (x_copy) begin
          mode  <= x_mode;
          cnt   <= x_cnt;
          nlen  <= x_nlen;
          par_p <= x_p;
          par_a <= arg_a;
          par_b <= x_b;
          k     <= '0;
          w     <= '0;
          pv    <= 1'b0;
        end
      end

      if (cmd.copy_run) begin
        if (copy_done) begin
          bank <= ~bank;
          wlen <= (mode == CM_PURGE) ? w : nlen;
        end else begin
          pv <= issue;
          if (issue) begin
            pk <= k;
            k  <= k + LW'(1);
          end
          if (pv && mode == CM_PURGE && keep) w <= w + LW'(1);
        end
      end

      if (cmd.emit_wr && out_free) begin
        result_valid <= 1'b1;
        e <= emit_last ? '0 : e + LW'(1);
        if (rej || wlen == '0) begin
          result <= '{out_char: 8'd0, char_valid: 1'b0, rejected: rej,
                      truncated: trunc, last_out: 1'b1};
        end else begin
          result <= '{out_char: rdata, char_valid: 1'b1, rejected: 1'b0,
                      truncated: trunc, last_out: emit_last};
        end
        if (emit_last) begin
          wlen  <= '0;
          trunc <= 1'b0;
          rej   <= 1'b0;
        end
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/word_mangling_rule_apply.sv @@
// after word end, each opcode is fetched in turn and each buffer pass copies the word
// into the other bank; each result byte is then read from the buffer and registered out
// throughput: one input byte per cycle while loading; one word at a time
// the copy passes run through the single read and write port of the word buffer
// reset: synchronous active high rst clears rule registers, lengths and flags
// word_mangling_rule_apply: top level joining wmr_ctrl and wmr_dp; uses wmr_pkg
module word_mangling_rule_apply (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         word_valid,
  output logic                         word_ready,
  input  wmr_pkg::word_item_t          word,
  output logic                         result_valid,
  input  logic                         result_ready,
  output wmr_pkg::result_item_t        result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [wmr_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [63:0]                  cfg_data
);
  import wmr_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  wmr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .word_valid (word_valid),
    .word_last  (word.last_char),
    .word_ready (word_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  wmr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .word         (word),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

@@ rtl/core/wmr_checker.sv @@
// wmr_checker: port-level checks on the result channel of the top level.
// Depends on wmr_pkg; bound to word_mangling_rule_apply below.
module wmr_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  result_valid,
  input logic                  result_ready,
  input wmr_pkg::result_item_t result
);
  import wmr_pkg::*;

  // stalled transfer holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.char_valid |-> result.last_out && result.out_char == 8'd0)
    else $error("empty result not single and zero");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.rejected |-> !result.char_valid)
    else $error("rejected result carries a byte");

  // truncated flag is the same across one word
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !result.last_out ##1 result_valid
      |-> result.truncated == $past(result.truncated))
    else $error("truncated flag changed within a word");

endmodule

bind word_mangling_rule_apply wmr_checker u_wmr_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

@@ dv/word_mangling_rule_apply_tb.sv @@
`timescale 1ns / 100ps
// word_mangling_rule_apply_tb: self-checking testbench for the word mangling rule block
// predicts each transformed word from the rule registers; depends on wmr_pkg and the rtl
module word_mangling_rule_apply_tb;
  import wmr_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic word_valid = 1'b0;
  logic word_ready;
  word_item_t word = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_item_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  always #2 clk = ~clk;

  word_mangling_rule_apply u_dut (
    .clk(clk), .rst(rst), .word_valid(word_valid), .word_ready(word_ready), .word(word),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor state
  logic [63:0] rule_regs [NRULE_REGS];
  logic [5:0] rule_len;
  logic [7:0] in_buf [MAX_WORD];
  int in_len;
  bit in_ovf;
  logic [7:0] wk [MAX_WORD];
  int wk_len;
  bit wk_trunc;

  result_item_t expected_chars[$];
  int errors = 0;
  int idle_cycles = 0;
  bit rx_noidle = 1'b0;
  bit tx_noidle = 1'b0;
  int hold_off = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic logic [7:0] rbyte(input int k);
    return rule_regs[(k >> 3) & 3][(k & 7) * 8 +: 8];
  endfunction

  function automatic int posn(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return c - CH_0;
    if (c >= CH_UA && c <= CH_UZ) return 10 + c - CH_UA;
    return -1;
  endfunction

  function automatic logic [7:0] lo(input logic [7:0] c);
    return (c >= CH_UA && c <= CH_UZ) ? c + 8'h20 : c;
  endfunction

  function automatic logic [7:0] up(input logic [7:0] c);
    return (c >= CH_LA && c <= CH_LZ) ? c - 8'h20 : c;
  endfunction

  function automatic void ins_at(input int p, input logic [7:0] ch);
    int stop;
    if (wk_len < MAX_WORD) begin
      for (int j = wk_len; j > p; j--) wk[j] = wk[j-1];
      wk[p] = ch;
      wk_len++;
      return;
    end
    wk_trunc = 1;
    if (p >= MAX_WORD) return;
    stop = MAX_WORD - 1;
    for (int j = stop; j > p; j--) wk[j] = wk[j-1];
    wk[p] = ch;
  endfunction

  function automatic bit run_rule_model();
    int rl, i, need, p, n, k;
    logic [7:0] op, a, b, t;
    rl = rule_len > MAX_RULE ? MAX_RULE : rule_len;
    i = 0;
    while (i < rl) begin
      op = rbyte(i);
      i++;
      need = 0;
      if (op inside {OP_DEL, OP_LESS, OP_MORE, OP_EQ, OP_APPEND, OP_PREPEND, OP_PURGE})
        need = 1;
      else if (op inside {OP_SUBST, OP_OVER, OP_INS})
        need = 2;
      if (i + need > rl) return 1;
      a = need > 0 ? rbyte(i) : 8'h0;
      b = need > 1 ? rbyte(i + 1) : 8'h0;
      p = posn(a);
      i += need;
      case (op)
        OP_NOP: ;
        OP_LOWER: for (int j = 0; j < wk_len; j++) wk[j] = lo(wk[j]);
        OP_UPPER: for (int j = 0; j < wk_len; j++) wk[j] = up(wk[j]);
        OP_CAP: for (int j = 0; j < wk_len; j++) wk[j] = j == 0 ? up(wk[j]) : lo(wk[j]);
        OP_ICAP: for (int j = 0; j < wk_len; j++) wk[j] = j == 0 ? lo(wk[j]) : up(wk[j]);
        OP_TOGGLE: for (int j = 0; j < wk_len; j++)
          wk[j] = (wk[j] >= CH_LA && wk[j] <= CH_LZ) ? up(wk[j]) : lo(wk[j]);
        OP_REV: for (int j = 0; j < wk_len / 2; j++) begin
          t = wk[j];
          wk[j] = wk[wk_len-1-j];
          wk[wk_len-1-j] = t;
        end
        OP_DUP, OP_REFL: begin
          n = wk_len;
          for (int j = 0; j < n; j++) begin
            if (n + j < MAX_WORD) wk[n+j] = op == OP_DUP ? wk[j] : wk[n-1-j];
            else wk_trunc = 1;
          end
          wk_len = 2 * n > MAX_WORD ? MAX_WORD : 2 * n;
        end
        OP_ROTL: if (wk_len > 0) begin
          t = wk[0];
          for (int j = 0; j < wk_len - 1; j++) wk[j] = wk[j+1];
          wk[wk_len-1] = t;
        end
        OP_ROTR: if (wk_len > 0) begin
          t = wk[wk_len-1];
          for (int j = wk_len - 1; j > 0; j--) wk[j] = wk[j-1];
          wk[0] = t;
        end
        OP_DROPF: if (wk_len > 0) begin
          for (int j = 0; j < wk_len - 1; j++) wk[j] = wk[j+1];
          wk_len--;
        end
        OP_DROPL: if (wk_len > 0) wk_len--;
        OP_DEL: if (p >= 0 && p < wk_len) begin
          for (int j = p; j < wk_len - 1; j++) wk[j] = wk[j+1];
          wk_len--;
        end
        OP_APPEND: if (wk_len < MAX_WORD) begin
          wk[wk_len] = a;
          wk_len++;
        end else wk_trunc = 1;
        OP_PREPEND: ins_at(0, a);
        OP_PURGE: begin
          k = 0;
          for (int j = 0; j < wk_len; j++) if (wk[j] != a) begin
            wk[k] = wk[j];
            k++;
          end
          wk_len = k;
        end
        OP_SUBST: for (int j = 0; j < wk_len; j++) if (wk[j] == a) wk[j] = b;
        OP_OVER: if (p >= 0 && p < wk_len) wk[p] = b;
        OP_INS: if (p >= 0 && p <= wk_len) ins_at(p, b);
        OP_LESS: if (wk_len >= p) return 1;
        OP_MORE: if (wk_len <= p) return 1;
        OP_EQ: if (wk_len != p) return 1;
        default: return 1;
      endcase
    end
    return 0;
  endfunction

  function automatic void predict_word(input word_item_t it);
    bit rej;
    result_item_t r;
    if (!it.no_char) begin
      if (in_len < MAX_WORD) begin
        in_buf[in_len] = it.word_char;
        in_len++;
      end else in_ovf = 1;
    end
    if (!it.last_char) return;
    for (int j = 0; j < in_len; j++) wk[j] = in_buf[j];
    wk_len = in_len;
    wk_trunc = in_ovf;
    rej = run_rule_model();
    in_len = 0;
    in_ovf = 0;
    if (rej || wk_len == 0) begin
      r = '0;
      r.rejected = rej;
      r.truncated = wk_trunc;
      r.last_out = 1'b1;
      expected_chars = {expected_chars, r};
      return;
    end
    for (int j = 0; j < wk_len; j++) begin
      r.out_char = wk[j];
      r.char_valid = 1'b1;
      r.rejected = 1'b0;
      r.truncated = wk_trunc;
      r.last_out = j + 1 == wk_len;
      expected_chars = {expected_chars, r};
    end
  endfunction

  // result checker with random stalls
  always @(posedge clk) begin
    result_item_t e;
    if (!rst && result_valid && result_ready) begin
      if (expected_chars.size() == 0) report($sformatf("unexpected result %h", result));
      else begin
        e = expected_chars.pop_front();
        if (result.out_char !== e.out_char)
          report($sformatf("out_char %h exp %h", result.out_char, e.out_char));
        if (result.char_valid !== e.char_valid)
          report($sformatf("char_valid %b exp %b", result.char_valid, e.char_valid));
        if (result.rejected !== e.rejected)
          report($sformatf("rejected %b exp %b", result.rejected, e.rejected));
        if (result.truncated !== e.truncated)
          report($sformatf("truncated %b exp %b", result.truncated, e.truncated));
        if (result.last_out !== e.last_out)
          report($sformatf("last_out %b exp %b", result.last_out, e.last_out));
      end
    end
  end

  int rx_gap = 0;
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      result_ready <= 1'b0;
    end else if (rx_noidle) result_ready <= 1'b1;
    else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      result_ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      rx_gap <= $urandom_range(1, 12) - 1;
      result_ready <= 1'b0;
    end else result_ready <= 1'b1;
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((word_valid && word_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] c, input bit none, input bit last);
    word_item_t it;
    if (!tx_noidle && $urandom_range(0, 9) == 0) begin
      word_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    it.word_char = c;
    it.no_char = none;
    it.last_char = last;
    word <= it;
    word_valid <= 1'b1;
    do @(posedge clk); while (!word_ready);
    predict_word(it);
  endtask

  task automatic send_word(input logic [7:0] w[$]);
    if (w.size() == 0) send_char(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    else foreach (w[j]) send_char(w[j], 1'b0, j == w.size() - 1);
  endtask

  task automatic drain();
    word_valid <= 1'b0;
    while (expected_chars.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [63:0] v);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NRULE_REGS) rule_regs[idx] = v;
    else if (idx == CFG_RULE_LEN) rule_len = v[5:0];
  endtask

  task automatic set_rule(input logic [7:0] r[$], input int len);
    logic [63:0] g [NRULE_REGS];
    foreach (g[k]) g[k] = '0;
    foreach (r[k]) if (k < 32) g[k/8][(k%8)*8 +: 8] = r[k];
    drain();
    for (int k = 0; k < NRULE_REGS; k++) write_reg(CFG_IW'(k), g[k]);
    write_reg(CFG_RULE_LEN, 64'(len));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] rand_char();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(CH_LA, CH_LZ));
      1: return 8'($urandom_range(CH_UA, CH_UZ));
      2: return 8'($urandom_range(CH_0, CH_9));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] rand_pos();
    return $urandom_range(0, 4) == 0 ? rand_char() : CH_0 + 8'($urandom_range(0, 9));
  endfunction

  function automatic void rand_word(ref logic [7:0] w[$], input int maxlen);
    w.delete();
    repeat ($urandom_range(0, maxlen)) w = {w, rand_char()};
  endfunction

  function automatic void add_op(ref logic [7:0] r[$]);
    logic [7:0] ops[] = '{OP_NOP, OP_LOWER, OP_UPPER, OP_CAP, OP_ICAP, OP_TOGGLE, OP_REV,
      OP_DUP, OP_REFL, OP_ROTL, OP_ROTR, OP_DROPF, OP_DROPL, OP_DEL, OP_APPEND,
      OP_PREPEND, OP_PURGE, OP_SUBST, OP_OVER, OP_INS, OP_LESS, OP_MORE, OP_EQ};
    logic [7:0] op;
    op = ops[$urandom_range(0, ops.size() - 1)];
    r = {r, op};
    if (op inside {OP_DEL, OP_OVER, OP_INS, OP_LESS, OP_MORE, OP_EQ}) r = {r, rand_pos()};
    if (op inside {OP_APPEND, OP_PREPEND, OP_PURGE, OP_SUBST}) r = {r, rand_char()};
    if (op inside {OP_SUBST, OP_OVER, OP_INS}) r = {r, rand_char()};
  endfunction

  task automatic test_reset_identity();
    logic [7:0] w[$];
    w = '{8'h00, 8'hFF, CH_LA, CH_UZ};
    send_word(w);
    w.delete();
    send_word(w);
  endtask

  task automatic test_each_opcode();
    logic [7:0] r[$];
    logic [7:0] w[$];
    logic [7:0] rules[][$] = '{
      '{OP_LOWER, OP_REV}, '{OP_UPPER, OP_DUP}, '{OP_CAP, OP_REFL, OP_ROTL},
      '{OP_ICAP, OP_ROTR, OP_DROPF}, '{OP_TOGGLE, OP_DROPL, OP_DEL, "1"},
      '{OP_APPEND, 8'hFF, OP_PREPEND, 8'h00}, '{OP_PURGE, "a", OP_SUBST, "b", "Z"},
      '{OP_OVER, "0", "x", OP_INS, "2", "y"}, '{OP_LESS, "Z", OP_MORE, "1", OP_EQ, "3"},
      '{OP_EQ, "#"}, '{OP_LESS, "#"}, '{OP_MORE, "#", OP_DEL, "#", OP_INS, "9", "q"},
      '{8'h01}, '{OP_SUBST, "a"}, '{OP_NOP}};
    foreach (rules[k]) begin
      set_rule(rules[k], rules[k].size());
      w = '{"a", "B", "c"};
      send_word(w);
    end
    // rule length beyond limit, full 32 bytes of toggles
    r.delete();
    repeat (32) r = {r, OP_TOGGLE};
    set_rule(r, 63);
    w = '{"a"};
    send_word(w);
  endtask

  task automatic test_overflow();
    logic [7:0] r[$];
    logic [7:0] w[$];
    r = '{OP_DUP, OP_PREPEND, "p", OP_INS, "5", "z", OP_APPEND, "e"};
    set_rule(r, r.size());
    rand_word(w, 0);
    repeat (70) w = {w, rand_char()};
    send_word(w);
    rand_word(w, 0);
    repeat (40) w = {w, rand_char()};
    send_word(w);
  endtask

  task automatic test_backpressure();
    logic [7:0] w[$];
    drain();
    hold_off = 600;
    repeat (4) begin
      rand_word(w, 12);
      send_word(w);
    end
    drain();
  endtask

  task automatic test_random(input int n_items, input bit quiet);
    logic [7:0] r[$];
    logic [7:0] w[$];
    int sent;
    sent = 0;
    while (sent < n_items) begin
      r.delete();
      repeat ($urandom_range(1, 6)) add_op(r);
      set_rule(r, $urandom_range(0, 5) == 0 ? $urandom_range(0, 32) : r.size());
      tx_noidle = quiet;
      rx_noidle = quiet;
      repeat ($urandom_range(1, 4)) begin
        rand_word(w, $urandom_range(0, 9) == 0 ? 66 : 10);
        send_word(w);
        sent += w.size() == 0 ? 1 : w.size();
      end
    end
  endtask

  initial begin
    for (int k = 0; k < NRULE_REGS; k++) rule_regs[k] = '0;
    rule_len = '0;
    in_len = 0;
    in_ovf = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_identity();
    test_each_opcode();
    test_overflow();
    test_backpressure();
    test_random(160, 1'b0);
    test_random(50, 1'b1);
    drain();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
